/* design/snesm_pkg.sv */
// Package for the serial mouse port: transfer payload types, operation codes and
// report layout constants. Depends on nothing; every other design file imports it.
package snesm_pkg;

  typedef enum logic [1:0] {
    OP_FRAME  = 2'd0,
    OP_STROBE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [7:0] x_delta;
    logic signed [7:0] y_delta;
    logic [1:0]        button_state;
    logic              strobe_value;
  } in_item_t;

  typedef struct packed {
    logic data_bit;
  } out_item_t;

  localparam int unsigned ReportWidth = 32;
  localparam int unsigned PosWidth    = 6;
  localparam logic [31:0] ReportIdBit = 32'h0001_0000;
  localparam logic [1:0]  SensMax     = 2'd2;

endpackage

/* design/snesm_in_if.sv */
// Input channel of the serial mouse port: valid/ready handshake with an item payload.
// Depends on snesm_pkg for the payload type.
interface snesm_in_if import snesm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/snesm_out_if.sv */
// Result channel of the serial mouse port: valid/ready handshake with one report bit.
// Depends on snesm_pkg for the payload type.
interface snesm_out_if import snesm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/snes_mouse_serial_port.sv */
// Serial mouse on a controller port: motion accumulators, report latch and bit reader.
// A read result appears in the output register in the cycle after its transfer.
// The port takes one item per cycle while its single output register is empty or the result sink
// takes the waiting bit; otherwise input ready is held low. The asynchronous active-low reset clears all state.
// Depends on snesm_pkg, snesm_in_if and snesm_out_if.
module snes_mouse_serial_port import snesm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  snesm_in_if.sink   in_i,
  snesm_out_if.source out_o
);

  logic [ReportWidth-1:0] report_q, report_d;
  logic [PosWidth-1:0]    pos_q, pos_d;
  logic                   strobe_q, strobe_d;
  logic [7:0]             x_acc_q, x_acc_d;
  logic [7:0]             y_acc_q, y_acc_d;
  logic [1:0]             buttons_q, buttons_d;
  logic [1:0]             sens_q, sens_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_bit_q, out_bit_d;

  logic     in_accept;
  logic     read_accept;
  logic     latch;
  logic [1:0] shift;
  logic     read_bit;
  in_item_t item;

  function automatic logic [7:0] fold_delta(logic [7:0] acc, logic [7:0] v, logic [1:0] sh);
    logic [7:0] mag;
    mag = v[7] ? (~v + 8'd1) : v;
    mag = mag >> sh;
    return v[7] ? (acc - mag) : (acc + mag);
  endfunction

  function automatic logic [7:0] sign_mag(logic [7:0] acc);
    logic [7:0] m;
    m = acc[7] ? (~acc + 8'd1) : acc;
    return {acc[7], m[6:0]};
  endfunction

  assign item        = in_i.data;
  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign in_accept   = in_i.valid & in_i.ready;
  assign read_accept = in_accept && (item.op == OP_READ);
  assign latch       = in_accept && (item.op == OP_STROBE) && strobe_q && !item.strobe_value;
  assign shift       = sens_q[1] ? 2'd0 : (SensMax - sens_q);
  assign read_bit    = (pos_q < PosWidth'(ReportWidth)) ? report_q[~pos_q[4:0]] : 1'b0;

  always_comb begin
    report_d  = report_q;
    pos_d     = pos_q;
    strobe_d  = strobe_q;
    x_acc_d   = x_acc_q;
    y_acc_d   = y_acc_q;
    buttons_d = buttons_q;
    sens_d    = sens_q;
    if (in_accept) begin
      unique case (item.op)
        OP_FRAME: begin
          buttons_d = item.button_state;
          x_acc_d   = fold_delta(x_acc_q, item.x_delta, shift);
          y_acc_d   = fold_delta(y_acc_q, item.y_delta, shift);
        end
        OP_STROBE: begin
          if (latch) begin
            report_d = ReportIdBit | {8'h00, buttons_q, sens_q, 4'h0,
                                      sign_mag(y_acc_q), sign_mag(x_acc_q)};
            x_acc_d  = 8'h00;
            y_acc_d  = 8'h00;
            pos_d    = '0;
          end
          strobe_d = item.strobe_value;
        end
        OP_READ: begin
          if (strobe_q) begin
            unique case (sens_q)
              2'd0:    sens_d = 2'd1;
              2'd1:    sens_d = 2'd2;
              2'd2:    sens_d = 2'd0;
              default: sens_d = 2'd1;
            endcase
          end
          if (pos_q < PosWidth'(ReportWidth)) begin
            pos_d = pos_q + PosWidth'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = read_accept | (out_valid_q & ~out_o.ready);
  assign out_bit_d   = read_accept ? read_bit : out_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_q    <= '0;
      pos_q       <= '0;
      strobe_q    <= 1'b0;
      x_acc_q     <= 8'h00;
      y_acc_q     <= 8'h00;
      buttons_q   <= 2'b00;
      sens_q      <= 2'b00;
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
    end else begin
      report_q    <= report_d;
      pos_q       <= pos_d;
      strobe_q    <= strobe_d;
      x_acc_q     <= x_acc_d;
      y_acc_q     <= y_acc_d;
      buttons_q   <= buttons_d;
      sens_q      <= sens_d;
      out_valid_q <= out_valid_d;
      out_bit_q   <= out_bit_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.data.data_bit = out_bit_q;

  // The bit pointer never runs past the end of the report.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosWidth'(ReportWidth))
    else $error("bit pointer beyond report length");

  // The sensitivity only cycles through its three legal levels.
  a_sens_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sens_q != 2'd3)
    else $error("sensitivity reached an unused level");

  // A read transfer always leaves a result waiting in the output register.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_accept |=> out_valid_q)
    else $error("read transfer produced no result");

  // A report latch clears the accumulators and the bit pointer and sets the report's ID bit.
  a_latch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch |=> (x_acc_q == 8'h00) && (y_acc_q == 8'h00) && (pos_q == '0)
              && report_q[16])
    else $error("report latch did not restart the report");

endmodule

/* test/snesm_report_check.sv */
// Monitor for the serial mouse port: predicts each report bit from the item transfers
// and compares it with the result transfers. Depends on snesm_pkg and both channel
// interfaces.
module snesm_report_check import snesm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  snesm_in_if  item_i,
  snesm_out_if result_i,
  output int   errors_o,
  output int   pending_o
);

  logic [31:0] report_q;
  logic [5:0]  bit_pos_q;
  logic        strobe_q;
  logic [7:0]  x_acc_q;
  logic [7:0]  y_acc_q;
  logic [1:0]  buttons_q;
  logic [1:0]  sens_q;
  logic        bits_due[$];

  function automatic logic [7:0] fold_motion(logic [7:0] acc, logic signed [7:0] delta,
                                             int unsigned shift);
    logic [8:0] mag;
    if (delta > 0) begin
      mag = {1'b0, delta};
      return acc + 8'(mag >> shift);
    end
    mag = (delta == 0) ? 9'd0 : 9'd256 - {1'b0, delta};
    return acc - 8'(mag >> shift);
  endfunction

  function automatic logic [7:0] sign_magnitude(logic [7:0] acc);
    logic [7:0] mag;
    mag = acc[7] ? 8'd0 - acc : acc;
    return {acc[7], mag[6:0]};
  endfunction

  task automatic flag_mismatch(string what, logic want, logic got);
    if (errors_o < 10) begin
      $display("report bit %s at %0t: expected %0b, got %0b", what, $time, want, got);
    end
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t    it;
    logic        want;
    logic        next_bit;
    int unsigned shift;
    if (!rst_ni) begin
      report_q  = '0;
      bit_pos_q = '0;
      strobe_q  = 1'b0;
      x_acc_q   = '0;
      y_acc_q   = '0;
      buttons_q = '0;
      sens_q    = '0;
      bits_due.delete();
      errors_o  = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (bits_due.size() == 0) begin
          flag_mismatch("with none expected", 1'b0, result_i.data.data_bit);
        end else begin
          want = bits_due.pop_front();
          if (want !== result_i.data.data_bit) begin
            flag_mismatch("mismatch", want, result_i.data.data_bit);
          end
        end
      end
      if (item_i.valid && item_i.ready) begin
        it = item_i.data;
        case (it.op)
          OP_FRAME: begin
            shift     = (sens_q >= SensMax) ? 0 : 2 - sens_q;
            buttons_q = it.button_state;
            x_acc_q   = fold_motion(x_acc_q, it.x_delta, shift);
            y_acc_q   = fold_motion(y_acc_q, it.y_delta, shift);
          end
          OP_STROBE: begin
            // A falling strobe latches the report and restarts the serial readout.
            if (strobe_q && !it.strobe_value) begin
              report_q        = ReportIdBit;
              report_q[21:20] = sens_q;
              report_q[23:22] = buttons_q;
              report_q[15:8]  = sign_magnitude(y_acc_q);
              report_q[7:0]   = sign_magnitude(x_acc_q);
              x_acc_q         = '0;
              y_acc_q         = '0;
              bit_pos_q       = '0;
            end
            strobe_q = it.strobe_value;
          end
          OP_READ: begin
            if (strobe_q) begin
              sens_q = 2'((int'(sens_q) + 1) % 3);
            end
            next_bit = 1'b0;
            if (bit_pos_q < ReportWidth) begin
              next_bit  = report_q[ReportWidth - 1 - bit_pos_q];
              bit_pos_q = bit_pos_q + 6'd1;
            end
            bits_due.push_back(next_bit);
          end
          default: begin
          end
        endcase
      end
    end
    pending_o = bits_due.size();
  end

endmodule

/* test/testbench.sv */
// Top of the serial mouse port test: clock, reset, item stimulus, result-side stalls
// and the verdict. Depends on snesm_pkg, the channel interfaces, the port itself and
// snesm_report_check, which predicts and compares the report bits.
module testbench;
  import snesm_pkg::*;

  localparam logic [1:0]  OpUndefined   = 2'd3;
  localparam int unsigned RandomItems   = 800;
  localparam int unsigned QuietItems    = 100;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned CycleLimit    = 200000;

  logic        clk    = 1'b0;
  logic        rst_n  = 1'b0;
  logic        flood  = 1'b0;
  logic        quiet  = 1'b0;
  int unsigned sent   = 0;
  int unsigned cycles = 0;
  int          errors;
  int          pending;

  snesm_in_if  item_if();
  snesm_out_if result_if();

  snes_mouse_serial_port DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (item_if),
    .out_o (result_if)
  );

  snesm_report_check report_check (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_i (result_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.op           = 2'($urandom);
    it.x_delta      = 8'($urandom);
    it.y_delta      = 8'($urandom);
    it.button_state = 2'($urandom);
    it.strobe_value = 1'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 15))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk); while (!item_if.ready);
    if (it.op != OpUndefined) begin
      sent++;
    end
  endtask

  task automatic send_frame(input logic [7:0] x, input logic [7:0] y, input logic [1:0] b);
    in_item_t it;
    it              = random_item();
    it.op           = OP_FRAME;
    it.x_delta      = x;
    it.y_delta      = y;
    it.button_state = b;
    send_item(it);
  endtask

  task automatic send_strobe(input logic level);
    in_item_t it;
    it              = random_item();
    it.op           = OP_STROBE;
    it.strobe_value = level;
    send_item(it);
  endtask

  task automatic send_read();
    in_item_t it;
    it    = random_item();
    it.op = OP_READ;
    send_item(it);
  endtask

  // Result side: random ready bursts, one long hold-off once the random part starts.
  initial begin
    result_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    while (!quiet) begin
      if (flood) begin
        result_if.ready <= 1'b0;
        flood = 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        result_if.ready <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
    result_if.ready <= 1'b1;
  end

  initial begin
    in_item_t    it;
    int unsigned reads;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    wait (rst_n);
    @(posedge clk);

    send_read();
    send_frame(8'h7F, 8'h80, 2'd3);
    send_frame(8'h80, 8'h7F, 2'd1);
    send_frame(8'h00, 8'h00, 2'd2);
    it    = '1;
    it.op = OpUndefined;
    send_item(it);
    send_strobe(1'b1);
    send_strobe(1'b1);
    send_strobe(1'b0);
    send_strobe(1'b0);
    repeat (4) send_read();
    // Reads with the strobe high step the sensitivity up to its top value.
    send_strobe(1'b1);
    send_read();
    send_read();
    send_strobe(1'b0);
    send_frame(8'h80, 8'h80, 2'd0);
    send_strobe(1'b1);
    send_strobe(1'b0);
    repeat (3) send_read();
    send_strobe(1'b1);
    send_read();
    send_strobe(1'b0);

    flood = 1'b1;
    while (sent < RandomItems) begin
      if (sent >= RandomItems - QuietItems) begin
        quiet = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        repeat ($urandom_range(0, 4)) send_frame(pick_delta(), pick_delta(), 2'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          send_strobe(1'b1);
          repeat ($urandom_range(1, 3)) send_read();
        end
        send_strobe(1'b1);
        send_strobe(1'b0);
        reads = ($urandom_range(0, 2) == 0) ? $urandom_range(32, 36) : $urandom_range(0, 10);
        repeat (reads) send_read();
      end else begin
        send_item(random_item());
      end
    end
    item_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
